FILE: src/lru_key_value_cache_top_defines.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// same-cycle implication
`define LKVC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");

// next-cycle implication
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");

`endif

FILE: src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Word types, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int DEFAULT_CAPACITY = 10;
  localparam logic signed [VAL_W-1:0] ABSENT_VALUE = -32'sd1;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PLAN,
    S_APPLY,
    S_TRIM,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic match;
    logic plan;
    logic apply;
    logic trim;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic trim_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/lkvc_ram.sv
// ----------------------------------------------------------------------------
// LRU key-value cache RAM
// Generic one-write, one-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: src/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Sequences match, plan, apply, trim and result load for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lkvc_pkg::sts_t sts_i,
  output lkvc_pkg::cmd_t     cmd_o
);

  lkvc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = lkvc_pkg::S_MATCH;
        end
      end
      lkvc_pkg::S_MATCH: state_d = lkvc_pkg::S_PLAN;
      lkvc_pkg::S_PLAN:  state_d = lkvc_pkg::S_APPLY;
      lkvc_pkg::S_APPLY: begin
        state_d = sts_i.trim_needed ? lkvc_pkg::S_TRIM : lkvc_pkg::S_FINISH;
      end
      lkvc_pkg::S_TRIM:  state_d = lkvc_pkg::S_FINISH;
      lkvc_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          state_d = lkvc_pkg::S_IDLE;
        end
      end
      default: state_d = lkvc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lkvc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lkvc_pkg::S_MATCH:  cmd_o.match  = 1'b1;
      lkvc_pkg::S_PLAN:   cmd_o.plan   = 1'b1;
      lkvc_pkg::S_APPLY:  cmd_o.apply  = 1'b1;
      lkvc_pkg::S_TRIM:   cmd_o.trim   = 1'b1;
      lkvc_pkg::S_FINISH: cmd_o.finish = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/lkvc_datapath.sv
// ----------------------------------------------------------------------------
// LRU key-value cache datapath
// Key lanes with parallel compare, age and valid per entry, value RAM,
// capacity register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lkvc_pkg::in_t                 in_data_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [lkvc_pkg::CAP_W-1:0]    cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output lkvc_pkg::out_t                     out_data_o,
  input  wire lkvc_pkg::cmd_t                cmd_i,
  output lkvc_pkg::sts_t                     sts_o
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int DefCap = (lkvc_pkg::DEFAULT_CAPACITY > MAX_ENTRIES) ?
                          MAX_ENTRIES : lkvc_pkg::DEFAULT_CAPACITY;

  // latched word
  lkvc_pkg::in_t req_q;

  // entry state
  logic [lkvc_pkg::KEY_W-1:0] key_mem_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     valid_q, valid_d;
  logic [IDX_W-1:0]           age_q [MAX_ENTRIES];
  logic [IDX_W-1:0]           age_d [MAX_ENTRIES];
  logic [OCC_W-1:0]           occ_q, occ_d;
  logic [lkvc_pkg::CAP_W-1:0] cap_q;
  logic [OCC_W-1:0]           cap_eff;

  // per-word scratch
  logic [MAX_ENTRIES-1:0] hit_vec_q, hit_vec_d;
  logic                   hit_q, hit_d;
  logic                   evict_q, evict_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic [OCC_W-1:0]       touch_age_q, touch_age_d;
  logic [IDX_W-1:0]       hit_idx, victim_idx, free_idx, hit_age;
  logic                   touch_en;
  logic                   is_put;

  // result
  logic                          out_valid_q;
  lkvc_pkg::out_t                out_q;
  logic [lkvc_pkg::VAL_W-1:0]    rd_data;

  assign is_put = (req_q.op == lkvc_pkg::OP_PUT);

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = OCC_W'(DefCap);
    end else if (32'(cap_q) > MAX_ENTRIES) begin
      cap_eff = OCC_W'(MAX_ENTRIES);
    end else begin
      cap_eff = OCC_W'(cap_q);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec_d[i] = valid_q[i] && (key_mem_q[i] == req_q.key);
    end
  end

  // one-hot to index, oldest entry, lowest free slot
  always_comb begin
    hit_idx    = '0;
    hit_age    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_vec_q[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
        hit_age = hit_age | age_q[i];
      end
      if (valid_q[i] && (OCC_W'(age_q[i]) == (occ_q - OCC_W'(1)))) begin
        victim_idx = victim_idx | IDX_W'(i);
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    hit_d   = |hit_vec_q;
    evict_d = (occ_q >= cap_eff);
    if (hit_d) begin
      slot_d      = hit_idx;
      touch_age_d = OCC_W'(hit_age);
    end else if (evict_d) begin
      slot_d      = victim_idx;
      touch_age_d = occ_q - OCC_W'(1);
    end else begin
      slot_d      = free_idx;
      touch_age_d = occ_q;
    end
  end

  // a hit or any put, also one that displaces the oldest entry, ages the others like a touch
  assign touch_en = hit_q || is_put;

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    occ_d   = occ_q;
    if (cmd_i.apply && touch_en) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i] && (OCC_W'(age_q[i]) < touch_age_q)) begin
          age_d[i] = age_q[i] + IDX_W'(1);
        end
        if (IDX_W'(i) == slot_q) begin
          age_d[i]   = '0;
          valid_d[i] = 1'b1;
        end
      end
      if (is_put && !hit_q && !evict_q) begin
        occ_d = occ_q + OCC_W'(1);
      end
    end else if (cmd_i.trim) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i] && (OCC_W'(age_q[i]) == (occ_q - OCC_W'(1)))) begin
          valid_d[i] = 1'b0;
          age_d[i]   = '0;
        end
      end
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= lkvc_pkg::CAP_W'(lkvc_pkg::DEFAULT_CAPACITY);
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      age_q   <= age_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.match) begin
      hit_vec_q <= hit_vec_d;
    end
    if (cmd_i.plan) begin
      hit_q       <= hit_d;
      evict_q     <= evict_d;
      slot_q      <= slot_d;
      touch_age_q <= touch_age_d;
    end
    if (cmd_i.apply && is_put && !hit_q) begin
      key_mem_q[slot_q] <= req_q.key;
    end
    if (cmd_i.finish) begin
      out_q.found <= hit_q;
      if (is_put) begin
        out_q.read_value <= '0;
      end else if (hit_q) begin
        out_q.read_value <= rd_data;
      end else begin
        out_q.read_value <= lkvc_pkg::ABSENT_VALUE;
      end
    end
  end

  lkvc_ram #(
    .Width(lkvc_pkg::VAL_W),
    .Depth(MAX_ENTRIES)
  ) u_value_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.apply && is_put),
    .wr_addr_i (slot_q),
    .wr_data_i (req_q.value),
    .rd_en_i   (cmd_i.apply && !is_put && hit_q),
    .rd_addr_i (slot_q),
    .rd_data_o (rd_data)
  );

  assign sts_o.trim_needed = is_put && hit_q && (occ_q > cap_eff);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

`default_nettype wire

FILE: src/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least recently used replacement.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one get or put word.
// Output channel (out_valid_o/out_ready_i/out_data_o) returns one result
// word per input: found flag and read value (stored value on a get hit,
// -1 on a get miss, 0 for a put).
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the capacity;
// it is always ready; the user must write it only while the cache is idle,
// as the block itself does not enforce it. The controller steps each input
// through load, match, plan, apply and finish, with a trim step between apply
// and finish when a put of a present key evicts an entry after the capacity
// was lowered; it takes a new input only after the last one is finished, as
// all steps share the single entry table and the value RAM port.
// Reset clears valid bits, ages and occupancy at once and loads capacity 10;
// no clearing pass is needed. If the receiver stalls, the result register
// holds its word; one more input is taken and processed, then the
// controller waits until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire lkvc_pkg::in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output lkvc_pkg::out_t                  out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [lkvc_pkg::CAP_W-1:0] cfg_data_i
);

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvc_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

FILE: src/lkvc_checker.sv
// ----------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire lkvc_pkg::out_t out_data_o
);

  `LKVC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  `LKVC_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  `LKVC_ASSERT_NEXT(a_no_instant_result, in_valid_i && in_ready_o && !out_valid_o, !out_valid_o)

  `LKVC_ASSERT_NOW(a_miss_value, out_valid_o && !out_data_o.found, out_data_o.read_value == 32'sd0 || out_data_o.read_value == -32'sd1)

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire

FILE: verif/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache result checker
// Watches the input, output and capacity channels, keeps its own copy of the
// cache contents and recency order, predicts one result word per accepted
// input word and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------

module lru_key_value_cache_checker
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_t              in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_t             out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int               errors_o,
  output int               outstanding_o
);

  logic [KEY_W-1:0] slot_key  [MAX_ENTRIES];
  logic [VAL_W-1:0] slot_val  [MAX_ENTRIES];
  logic             slot_used [MAX_ENTRIES];
  logic [3:0]       slot_age  [MAX_ENTRIES];
  int unsigned      fill;
  logic [CAP_W-1:0] capacity_reg;

  out_t             pending_results[$];
  int               fail_count = 0;
  int               pending_count = 0;

  assign errors_o      = fail_count;
  assign outstanding_o = pending_count;

  // move slot s to the front of the recency order
  function automatic void make_recent(int s);
    int i;
    for (i = 0; i < MAX_ENTRIES; i++)
      if (slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = '0;
  endfunction

  function automatic int drop_oldest();
    int i;
    int oldest;
    oldest = -1;
    for (i = 0; i < MAX_ENTRIES; i++)
      if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
    if (oldest >= 0) begin
      slot_used[oldest] = 1'b0;
      slot_age[oldest]  = '0;
      if (fill > 0) fill--;
    end
    return oldest;
  endfunction

  function automatic out_t cache_access(in_t w);
    out_t        r;
    int          i;
    int          hit;
    int          slot;
    int unsigned lim;
    lim = (capacity_reg == '0) ? DEFAULT_CAPACITY : capacity_reg;
    if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
    hit = -1;
    for (i = 0; i < MAX_ENTRIES; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == w.key) hit = i;
    r.found      = (hit >= 0);
    r.read_value = '0;
    if (w.op == OP_GET) begin
      if (hit >= 0) begin
        make_recent(hit);
        r.read_value = slot_val[hit];
      end else begin
        r.read_value = ABSENT_VALUE;
      end
      return r;
    end
    if (hit >= 0) begin
      slot_val[hit] = w.value;
      make_recent(hit);
      if (fill > lim) slot = drop_oldest();
      return r;
    end
    if (fill >= lim || fill >= MAX_ENTRIES) slot = drop_oldest();
    slot = -1;
    for (i = 0; i < MAX_ENTRIES; i++)
      if (slot < 0 && !slot_used[i]) slot = i;
    if (slot < 0) slot = drop_oldest();
    if (slot >= 0) begin
      for (i = 0; i < MAX_ENTRIES; i++)
        if (slot_used[i]) slot_age[i]++;
      slot_key[slot]  = w.key;
      slot_val[slot]  = w.value;
      slot_used[slot] = 1'b1;
      slot_age[slot]  = '0;
      fill++;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    out_t want;
    int   i;
    if (!rst_ni) begin
      for (i = 0; i < MAX_ENTRIES; i++) begin
        slot_key[i]  = '0;
        slot_val[i]  = '0;
        slot_used[i] = 1'b0;
        slot_age[i]  = '0;
      end
      fill         = 0;
      capacity_reg = CAP_W'(DEFAULT_CAPACITY);
      pending_results.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word found=%0b read_value=%08h", $time,
                   out_data_i.found, out_data_i.read_value);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_i.found !== want.found) begin
            $display("%0t: found expected %0b actual %0b", $time, want.found,
                     out_data_i.found);
            fail_count++;
          end
          if (out_data_i.read_value !== want.read_value) begin
            $display("%0t: read_value expected %08h actual %08h", $time,
                     want.read_value, out_data_i.read_value);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i === 1'b1) capacity_reg = cfg_data_i;
      if (in_valid_i && in_ready_i === 1'b1) pending_results.push_back(cache_access(in_data_i));
    end
    pending_count <= pending_results.size();
  end

endmodule

FILE: verif/lru_key_value_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put words with random gaps and output stalls, walks the
// capacity through its extremes and a lowering below occupancy, and holds the
// output off once so the cache backs up. The checker predicts and compares.
// ----------------------------------------------------------------------------

module lru_key_value_cache_top_tb;
  import lkvc_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 85;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  out_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i;

  int               errors;
  int               outstanding;
  int               cycles = 0;
  bit               steady = 1'b0;
  bit               hold_req = 1'b0;
  logic [KEY_W-1:0] key_pool[24];
  int               pool_size = 1;
  logic [CAP_W-1:0] capacity_plan[PHASES] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3,
                                              5'd17, 5'd2, 5'd12, 5'd5, 5'd16};

  lru_key_value_cache_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  lru_key_value_cache_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result receiver: random stalls, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i = steady || ($urandom_range(99) >= 7);
    end
  end

  function automatic logic [31:0] boundary_word();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic in_t make_word(op_e op, logic [31:0] k, logic [31:0] v);
    in_t w;
    w.op    = op;
    w.key   = k;
    w.value = v;
    return w;
  endfunction

  function automatic in_t random_word();
    int          sel;
    logic [31:0] k;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 85) k = key_pool[$urandom_range(pool_size - 1)];
    else if (sel < 95) k = $urandom;
    else k = boundary_word();
    v = ($urandom_range(9) == 0) ? boundary_word() : $urandom;
    return make_word(($urandom_range(1) == 1) ? OP_PUT : OP_GET, k, v);
  endfunction

  task automatic send_word(in_t w);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // drop valid, drain all results, then let the controller settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = c;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(int n, bit with_hold);
    int i;
    pool_size = $urandom_range(2, 24);
    for (i = 0; i < pool_size; i++) key_pool[i] = $urandom;
    for (i = 0; i < n; i++) begin
      send_word(random_word());
      if (with_hold && i == n / 3) hold_req = 1'b1;
    end
  endtask

  initial begin
    int p;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty miss, extreme keys and values, overwrite, eviction at 10
    steady = 1'b1;
    send_word(make_word(OP_GET, 32'h0000_0000, 32'h1234_5678));
    send_word(make_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(make_word(OP_PUT, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 32'h8000_0000, 32'h0));
    send_word(make_word(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(OP_GET, 32'h0000_0000, 32'h0));
    send_word(make_word(OP_GET, 32'hFFFF_FFFF, 32'h0));
    send_word(make_word(OP_PUT, 32'h7FFF_FFFF, 32'hA5A5_5A5A));
    send_word(make_word(OP_GET, 32'h7FFF_FFFF, 32'h0));
    for (p = 0; p < 8; p++) send_word(make_word(OP_PUT, 32'd100 + p, 32'hC000_0000 | p));
    send_word(make_word(OP_GET, 32'h8000_0000, 32'h0));
    send_word(make_word(OP_GET, 32'h0000_0000, 32'h0));
    send_word(make_word(OP_GET, 32'd107, 32'h0));
    steady = 1'b0;

    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      write_capacity(capacity_plan[p]);
      steady = (p == 2);
      run_random(PHASE_WORDS, p == 0);
    end
    steady = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
